>>> rtl/sbmd_pkg.sv
// Package for the block-matching disparity engine: shared types, constants and the pixel cost function.
// No dependencies.
`default_nettype none
package sbmd_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_PICK,
        ST_OUT
    } t_state;
    localparam int unsigned DEPTH_MID = 128;
    localparam int unsigned REG_WIDTH = 0;
    localparam int unsigned REG_HEIGHT = 1;
    localparam int unsigned ACT_LOAD = 0;

    function automatic logic [9:0] pixel_cost(input logic [23:0] p, input logic [23:0] q);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        a = (p[23:16] > q[23:16]) ? p[23:16] - q[23:16] : q[23:16] - p[23:16];
        b = (p[15:8] > q[15:8]) ? p[15:8] - q[15:8] : q[15:8] - p[15:8];
        c = (p[7:0] > q[7:0]) ? p[7:0] - q[7:0] : q[7:0] - p[7:0];
        return {2'b00, a} + {2'b00, b} + {2'b00, c};
    endfunction
endpackage
`default_nettype wire

>>> rtl/sbmd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sbmd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/sbmd_cell.sv
// One shift cell: accumulates SAD and valid count for one shift.
// Right pixels pass from cell to cell; depends on sbmd_pkg.
`default_nettype none
module sbmd_cell #(
    parameter int SAD_W = 18,
    parameter int CNT_W = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_clear,
    input  wire logic             i_en,
    input  wire logic [23:0]      i_left,
    input  wire logic             i_lvalid,
    input  wire logic [23:0]      i_right,
    input  wire logic             i_rvalid,
    output logic      [23:0]      o_right,
    output logic                  o_rvalid,
    output logic      [SAD_W-1:0] o_sad,
    output logic      [CNT_W-1:0] o_cnt
);
    logic [23:0]      r_right;
    logic             r_rvalid;
    logic [SAD_W-1:0] r_sad;
    logic [CNT_W-1:0] r_cnt;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_right  <= i_right;
            r_rvalid <= i_rvalid;
        end
        if (i_clear) begin
            r_sad <= '0;
            r_cnt <= '0;
        end else if (i_en && i_lvalid && i_rvalid) begin
            r_sad <= r_sad + SAD_W'(sbmd_pkg::pixel_cost(i_left, i_right));
            r_cnt <= r_cnt + 1'b1;
        end
    end
    assign o_right  = r_right;
    assign o_rvalid = r_rvalid;
    assign o_sad    = r_sad;
    assign o_cnt    = r_cnt;
endmodule
`default_nettype wire

>>> rtl/sad_block_matching_disparity_top.sv
// Top level of the SAD block-matching disparity engine: frame stores, cell row,
// sequencer and winner selection. Depends on sbmd_pkg, sbmd_ram and sbmd_cell.
// A load beat writes its pixel pair into both frame stores and the engine stays idle.
// A compute beat streams, for each of the WINDOW_SIZE window rows,
// WINDOW_SIZE+2*MAX_SHIFT-1 right pixels through a row of 2*MAX_SHIFT shift cells (each
// cell holds one shift's cost). A drain state, a winner selection that visits every
// cell and an output state follow. The result is held in an output register until
// taken; new beats are accepted meanwhile, and a following compute waits in its output
// state until that register is free.
`default_nettype none
module sad_block_matching_disparity_top #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int WINDOW_SIZE = 10,
    parameter int MAX_SHIFT   = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: x[7:0], y[15:8], left_red[23:16], left_green[31:24], left_blue[39:32],
    // right_red[47:40], right_green[55:48], right_blue[63:56]
    input  wire logic [63:0] s_axis_tdata,
    // tuser: action
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: out_x[7:0], out_y[15:8], disparity[21:16], depth_level[29:22], zero fill
    output logic [31:0]      m_axis_tdata
);
    localparam int NC    = 2 * MAX_SHIFT;
    localparam int HALF  = WINDOW_SIZE / 2;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int CNT_W = $clog2(WINDOW_SIZE * WINDOW_SIZE + 1);
    localparam int SAD_W = CNT_W + 10;
    localparam int PRW   = SAD_W + CNT_W;
    localparam int STREAM = WINDOW_SIZE + NC - 1;
    localparam int SW    = $clog2(STREAM + 1);
    localparam int RW    = $clog2(WINDOW_SIZE + 1);
    localparam int CW    = $clog2(NC + 1);
    localparam int PW    = 14;

    sbmd_pkg::t_state r_state, n_state;
    logic [8:0] r_width, r_height;
    logic [7:0] r_cx, r_cy;
    logic [SW-1:0] r_step;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_pick;
    logic r_pv, r_pvl, r_pvr;
    logic signed [PW-1:0] r_lx;
    logic signed [PW-1:0] r_py;
    logic r_have;
    logic [SAD_W-1:0] r_bsad;
    logic [CNT_W-1:0] r_bcnt;
    logic [CW-1:0] r_bidx;
    logic [31:0] r_out;
    logic r_ovalid;

    logic accept;
    logic load_we;
    logic out_free;
    logic signed [PW-1:0] w_s, h_s, py, qx, lx;
    logic inrow, qvalid, lvalid;
    logic [AW-1:0] waddr, laddr, raddr;
    logic [23:0] lpix, rpix;
    logic clear, en;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == sbmd_pkg::ST_IDLE);
    assign out_free = !r_ovalid || m_axis_tready;
    assign w_s = (PW'(r_width) > PW'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : PW'(r_width);
    assign h_s = (PW'(r_height) > PW'(MAX_HEIGHT)) ? PW'(MAX_HEIGHT) : PW'(r_height);
    assign py = $signed({6'd0, r_cy}) + $signed(PW'(r_row)) - PW'(HALF);
    assign inrow = (py >= 0) && (py < h_s);
    // Right pixel streamed at step s is qx = cx - HALF - MAX_SHIFT + s.
    assign qx = $signed({6'd0, r_cx}) - PW'(HALF + MAX_SHIFT) + $signed(PW'(r_step));
    assign qvalid = inrow && (qx >= 0) && (qx < w_s);
    // The broadcast left pixel px = qx - MAX_SHIFT + 1 meets, in cell j, the right
    // pixel streamed j steps earlier, which is the pair for that cell's shift.
    assign lx = qx - PW'(MAX_SHIFT - 1);
    assign lvalid = inrow && (lx >= 0) && (lx < w_s)
                    && ($signed(PW'(r_step)) - PW'(NC - 1) >= 0);
    assign load_we = accept && (s_axis_tuser[0] == 1'(sbmd_pkg::ACT_LOAD))
                     && (PW'(s_axis_tdata[7:0]) < PW'(MAX_WIDTH))
                     && (PW'(s_axis_tdata[15:8]) < PW'(MAX_HEIGHT));
    assign waddr = {YW'(s_axis_tdata[15:8]), XW'(s_axis_tdata[7:0])};
    assign raddr = {py[YW-1:0], qx[XW-1:0]};
    assign laddr = {py[YW-1:0], lx[XW-1:0]};
    assign clear = accept;
    assign en = r_pv;

    sbmd_ram #(.WIDTH(24), .DEPTH(1 << AW)) u_left (
        .i_clk(i_clk), .i_we(load_we),
        .i_waddr(waddr), .i_wdata(s_axis_tdata[39:16]), .i_raddr(laddr), .o_rdata(lpix));
    sbmd_ram #(.WIDTH(24), .DEPTH(1 << AW)) u_right (
        .i_clk(i_clk), .i_we(load_we),
        .i_waddr(waddr), .i_wdata(s_axis_tdata[63:40]), .i_raddr(raddr), .o_rdata(rpix));

    logic [23:0]      c_r  [NC+1];
    logic             c_rv [NC+1];
    logic [SAD_W-1:0] c_sad [NC];
    logic [CNT_W-1:0] c_cnt [NC];
    assign c_r[0]  = rpix;
    assign c_rv[0] = r_pvr;

    // Cell j holds shift MAX_SHIFT-1-j; the right pixel reaching it lags j steps.
    for (genvar j = 0; j < NC; j++) begin : g_cell
        sbmd_cell #(.SAD_W(SAD_W), .CNT_W(CNT_W)) u_cell (
            .i_clk(i_clk), .i_clear(clear), .i_en(en),
            .i_left(lpix), .i_lvalid(r_pvl),
            .i_right(c_r[j]), .i_rvalid(c_rv[j]),
            .o_right(c_r[j+1]), .o_rvalid(c_rv[j+1]),
            .o_sad(c_sad[j]), .o_cnt(c_cnt[j]));
    end

    logic [CW-1:0] cidx;
    logic [SAD_W-1:0] psad;
    logic [CNT_W-1:0] pcnt;
    logic better;
    logic signed [CW:0] shift;
    assign cidx = CW'(NC - 1) - r_pick;
    assign psad = c_sad[cidx[$clog2(NC > 1 ? NC : 2)-1:0]];
    assign pcnt = c_cnt[cidx[$clog2(NC > 1 ? NC : 2)-1:0]];
    assign better = (pcnt != 0) && (!r_have ||
                    ((PRW'(psad) * PRW'(r_bcnt)) < (PRW'(r_bsad) * PRW'(pcnt))));
    assign shift = (CW+1)'(MAX_SHIFT - 1) - $signed({1'b0, r_bidx});

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbmd_pkg::ST_IDLE: begin
                if (accept && s_axis_tuser[0] != 1'(sbmd_pkg::ACT_LOAD)) begin
                    n_state = sbmd_pkg::ST_RUN;
                end
            end
            sbmd_pkg::ST_RUN: begin
                if (r_step == SW'(STREAM - 1) && r_row == RW'(WINDOW_SIZE - 1)) begin
                    n_state = sbmd_pkg::ST_DRAIN;
                end
            end
            sbmd_pkg::ST_DRAIN: n_state = sbmd_pkg::ST_PICK;
            sbmd_pkg::ST_PICK: begin
                if (r_pick == CW'(NC - 1)) begin
                    n_state = sbmd_pkg::ST_OUT;
                end
            end
            sbmd_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = sbmd_pkg::ST_IDLE;
                end
            end
            default: n_state = sbmd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sbmd_pkg::ST_IDLE;
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == 1'(sbmd_pkg::REG_WIDTH)) r_width <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == 1'(sbmd_pkg::REG_HEIGHT)) r_height <= i_cfg_data;
            r_pv <= (r_state == sbmd_pkg::ST_RUN);
            if (r_state == sbmd_pkg::ST_OUT && out_free) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pvl <= lvalid;
        r_pvr <= qvalid;
        r_lx  <= lx;
        r_py  <= py;
        if (accept) begin
            r_cx   <= s_axis_tdata[7:0];
            r_cy   <= s_axis_tdata[15:8];
            r_step <= '0;
            r_row  <= '0;
            r_pick <= '0;
            r_have <= 1'b0;
            r_bidx <= '0;
        end
        if (r_state == sbmd_pkg::ST_RUN) begin
            if (r_step == SW'(STREAM - 1)) begin
                r_step <= '0;
                r_row  <= r_row + 1'b1;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
        if (r_state == sbmd_pkg::ST_PICK) begin
            r_pick <= r_pick + 1'b1;
            if (better) begin
                r_have <= 1'b1;
                r_bsad <= psad;
                r_bcnt <= pcnt;
                r_bidx <= cidx;
            end
        end
        if (r_state == sbmd_pkg::ST_OUT && out_free) begin
            r_out <= {2'b00,
                      r_have ? 8'(sbmd_pkg::DEPTH_MID) + 8'(shift)
                             : 8'(sbmd_pkg::DEPTH_MID - MAX_SHIFT),
                      r_have ? 6'(shift) : 6'(-MAX_SHIFT), r_cy, r_cx};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_state != sbmd_pkg::ST_IDLE && s_axis_tready) begin
            $error("input ready while busy");
        end
        if (i_rst_n && r_pvl && (r_lx < 0 || r_py < 0)) begin
            $error("left pixel marked valid outside the image");
        end
    end

    a_out_after_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbmd_pkg::ST_OUT) |=> m_axis_tvalid)
        else $error("result not presented after selection");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
`default_nettype wire
